### design/kbwe_pkg.sv
// ----------------------------------------------------------------------------
// kbwe_pkg
// Shared types, constants and the symbol code lookup for the k-mer window
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kbwe_pkg;

    // Parameter defaults
    localparam int K_MAX_DEF         = 6;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Field widths
    localparam int SYMBOL_W   = 8;
    localparam int FEATURE_W  = 32;
    localparam int INDEX_W    = 16;
    localparam int KMER_W     = 3;
    localparam int STRIDE_W   = 8;
    localparam int SEGMENT_W  = 16;
    localparam int SKIP_W     = 16;
    localparam int SCALE_W    = 53;
    localparam int CHARPOS_W  = 17;
    localparam int CODE_W     = 4;
    localparam int WIN_W      = 24;          // window value carried in the queue
    localparam int SPLIT_W    = 24;          // low part of scale factor
    localparam int SCALE_HI_W = SCALE_W - SPLIT_W;
    localparam int PROD_HI_W  = WIN_W + SCALE_HI_W;
    localparam int PROD_W     = PROD_HI_W + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = SCALE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_KMER_LEN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_STRIDE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_COUNT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 3'd4;

    localparam logic [KMER_W-1:0]    KMER_LEN_RST      = 3'd3;
    localparam logic [STRIDE_W-1:0]  WINDOW_STRIDE_RST = 8'd3;
    localparam logic [SEGMENT_W-1:0] SEGMENT_LEN_RST   = 16'd28500;
    localparam logic [SKIP_W-1:0]    SKIP_COUNT_RST    = 16'd200;
    localparam logic [SCALE_W-1:0]   SCALE_FACTOR_RST  = 53'd8798241030272;

    // Q.30 constants
    localparam logic [FEATURE_W-1:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [PROD_W-1:0]    Q30_SAT_LIM = PROD_W'(64'h8000_0000);

    typedef logic [SYMBOL_W-1:0] symbol_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                final_char;
    } in_t;

    typedef struct packed {
        logic signed [FEATURE_W-1:0] feature;
        logic [INDEX_W-1:0]          window_index;
        logic                        has_feature;
        logic                        bad_symbol;
        logic                        end_of_sequence;
    } out_t;

    typedef struct packed {
        logic [KMER_W-1:0]    kmer_len;
        logic [STRIDE_W-1:0]  window_stride;
        logic [SEGMENT_W-1:0] segment_len;
        logic [SKIP_W-1:0]    skip_count;
        logic [SCALE_W-1:0]   scale_factor;
    } cfg_t;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [INDEX_W-1:0] window_index;
        logic               has_feature;
        logic               bad_symbol;
        logic               end_of_sequence;
    } entry_t;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
    } code_t;

    // "AMVHCRSNWUYBGKDT"
    localparam symbol_t CODE_TABLE [16] = '{
        8'h41, 8'h4D, 8'h56, 8'h48, 8'h43, 8'h52, 8'h53, 8'h4E,
        8'h57, 8'h55, 8'h59, 8'h42, 8'h47, 8'h4B, 8'h44, 8'h54
    };

    // Letters are distinct, so at most one entry matches
    function automatic code_t code_lookup(input symbol_t sym);
        code_t res;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (CODE_TABLE[i] == sym)
            begin
                res.found = 1'b1;
                res.code  = CODE_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/kbwe_stream_if.sv
// ----------------------------------------------------------------------------
// kbwe_stream_if
// Valid/ready stream channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbwe_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/kbwe_front.sv
// ----------------------------------------------------------------------------
// kbwe_front
// Accepts characters, tracks sequence position, window value and stride
// phase, and queues one entry per window or final character.
// ----------------------------------------------------------------------------
`default_nettype none

module kbwe_front #(
    parameter int K_MAX         = kbwe_pkg::K_MAX_DEF,
    parameter int POSITION_BITS = kbwe_pkg::POSITION_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kbwe_pkg::cfg_t   cfg,
    kbwe_stream_if.sink           chars,
    input  wire logic             queue_full,
    output logic                  push,
    output kbwe_pkg::entry_t      push_data
);

    localparam int WB  = 4 * K_MAX;
    localparam int SBW = $clog2(K_MAX + 1);
    localparam int PB  = POSITION_BITS;
    localparam int CW  = kbwe_pkg::CHARPOS_W;
    localparam int KW  = kbwe_pkg::KMER_W;
    localparam int SW  = kbwe_pkg::STRIDE_W;

    logic [CW-1:0]  char_pos_reg, char_pos_next;
    logic [WB-1:0]  window_reg, window_next;
    logic [SW-1:0]  phase_reg, phase_next;
    logic [PB-1:0]  windows_reg, windows_next;
    logic [SBW-1:0] since_bad_reg, since_bad_next;

    logic [KW-1:0]  eff_k;
    logic [SW-1:0]  eff_stride;
    logic [WB-1:0]  mask;
    logic [WB+3:0]  shifted;
    logic [CW-1:0]  p;
    logic           active, complete, aligned, in_seg, emit, bad, accept;
    kbwe_pkg::code_t lk;
    logic [WB+kbwe_pkg::WIN_W-1:0] win_ext;
    logic [PB+kbwe_pkg::INDEX_W-1:0] idx_ext;
    logic [SBW-1:0] since_upd;
    logic [SW-1:0]  phase_upd;
    logic [WB-1:0]  window_upd;

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && chars.ready;

    always_comb
    begin
        if (cfg.kmer_len == '0)
            eff_k = KW'(1);
        else if (cfg.kmer_len > KW'(K_MAX))
            eff_k = KW'(K_MAX);
        else
            eff_k = cfg.kmer_len;
        eff_stride = (cfg.window_stride == '0) ? SW'(1) : cfg.window_stride;

        for (int j = 0; j < WB; j++)
        begin
            mask[j] = (KW'(j / 4) < eff_k);
        end

        lk      = kbwe_pkg::code_lookup(chars.data.symbol);
        active  = char_pos_reg >= {1'b0, cfg.skip_count};
        p       = char_pos_reg - {1'b0, cfg.skip_count};
        shifted = {window_reg, lk.code};
        window_upd = shifted[WB-1:0] & mask;

        if (!lk.found)
            since_upd = '0;
        else if (since_bad_reg < SBW'(K_MAX))
            since_upd = since_bad_reg + SBW'(1);
        else
            since_upd = since_bad_reg;

        complete = ({1'b0, p} + (CW+1)'(1)) >= (CW+1)'(eff_k);
        aligned  = phase_reg == '0;
        in_seg   = p < {1'b0, cfg.segment_len};
        phase_upd = (({1'b0, phase_reg} + (SW+1)'(1)) >= {1'b0, eff_stride}) ?
                    '0 : phase_reg + SW'(1);

        emit = active && complete && aligned && in_seg;
        bad  = since_upd < SBW'(eff_k);

        win_ext = {{kbwe_pkg::WIN_W{1'b0}}, window_upd};
        idx_ext = {{kbwe_pkg::INDEX_W{1'b0}}, windows_reg};

        push_data.window          = emit ? win_ext[kbwe_pkg::WIN_W-1:0] : '0;
        push_data.window_index    = emit ? idx_ext[kbwe_pkg::INDEX_W-1:0] : '0;
        push_data.has_feature     = emit;
        push_data.bad_symbol      = emit && bad;
        push_data.end_of_sequence = chars.data.final_char;
        push = accept && (emit || chars.data.final_char);

        char_pos_next  = char_pos_reg;
        window_next    = window_reg;
        phase_next     = phase_reg;
        windows_next   = windows_reg;
        since_bad_next = since_bad_reg;
        if (accept)
        begin
            if (chars.data.final_char)
            begin
                char_pos_next  = '0;
                window_next    = '0;
                phase_next     = '0;
                windows_next   = '0;
                since_bad_next = SBW'(K_MAX);
            end
            else
            begin
                if (char_pos_reg != '1)
                    char_pos_next = char_pos_reg + CW'(1);
                if (active)
                begin
                    window_next    = window_upd;
                    since_bad_next = since_upd;
                    if (complete)
                        phase_next = phase_upd;
                end
                if (emit && windows_reg != '1)
                    windows_next = windows_reg + PB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg  <= '0;
            window_reg    <= '0;
            phase_reg     <= '0;
            windows_reg   <= '0;
            since_bad_reg <= SBW'(K_MAX);
        end
        else
        begin
            char_pos_reg  <= char_pos_next;
            window_reg    <= window_next;
            phase_reg     <= phase_next;
            windows_reg   <= windows_next;
            since_bad_reg <= since_bad_next;
        end
    end

    a_since_bad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        since_bad_reg <= SBW'(K_MAX))
        else $error("since_bad counter beyond kmer maximum");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

### design/kbwe_fifo.sv
// ----------------------------------------------------------------------------
// kbwe_fifo
// Short queue decoupling the classifying front from the scaling back.
// ----------------------------------------------------------------------------
`default_nettype none

module kbwe_fifo #(
    parameter int DEPTH = kbwe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kbwe_pkg::entry_t  push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   valid,
    output kbwe_pkg::entry_t       head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    kbwe_pkg::entry_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;
    logic           do_pop;

    assign full   = count_reg == CNW'(DEPTH);
    assign valid  = count_reg != '0;
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !do_pop)
            count_next = count_reg + CNW'(1);
        else if (!push && do_pop)
            count_next = count_reg - CNW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

### design/kbwe_back.sv
// ----------------------------------------------------------------------------
// kbwe_back
// Scales queued window values to signed Q.30: split multiply, then add,
// offset and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kbwe_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [kbwe_pkg::SCALE_W-1:0] scale_factor,
    input  wire logic                         entry_valid,
    input  wire kbwe_pkg::entry_t             entry,
    output logic                              pop,
    kbwe_stream_if.source                     features
);

    localparam int SPW = kbwe_pkg::SPLIT_W;
    localparam int HW  = kbwe_pkg::SCALE_HI_W;
    localparam int PHW = kbwe_pkg::PROD_HI_W;
    localparam int PW  = kbwe_pkg::PROD_W;
    localparam int FW  = kbwe_pkg::FEATURE_W;

    logic                    en1, en2;
    logic                    s1_valid_reg, s1_valid_next;
    logic [PHW-1:0]          prod_hi_reg;
    logic [SPW-1:0]          prod_lo_reg;
    kbwe_pkg::entry_t        s1_entry_reg;
    logic [2*SPW-1:0]        prod_lo_full;
    logic                    out_valid_reg, out_valid_next;
    kbwe_pkg::out_t          out_data_reg, out_data_next;
    logic [PW-1:0]           sum;
    logic [FW-1:0]           scaled;

    assign en2 = !out_valid_reg || features.ready;
    assign en1 = !s1_valid_reg || en2;
    assign pop = en1 && entry_valid;

    assign prod_lo_full = entry.window * scale_factor[SPW-1:0];

    always_comb
    begin
        s1_valid_next  = en1 ? entry_valid : s1_valid_reg;
        out_valid_next = en2 ? s1_valid_reg : out_valid_reg;

        sum = {1'b0, prod_hi_reg} + PW'(prod_lo_reg);
        if (sum >= kbwe_pkg::Q30_SAT_LIM)
            scaled = kbwe_pkg::Q30_ONE;
        else
            scaled = sum[FW-1:0] - kbwe_pkg::Q30_ONE;

        out_data_next.feature         = s1_entry_reg.has_feature ? $signed(scaled) : '0;
        out_data_next.window_index    = s1_entry_reg.window_index;
        out_data_next.has_feature     = s1_entry_reg.has_feature;
        out_data_next.bad_symbol      = s1_entry_reg.bad_symbol;
        out_data_next.end_of_sequence = s1_entry_reg.end_of_sequence;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_hi_reg  <= entry.window * scale_factor[SPW+HW-1:SPW];
            prod_lo_reg  <= prod_lo_full[2*SPW-1:SPW];
            s1_entry_reg <= entry;
        end
        if (en2 && s1_valid_reg)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign features.valid = out_valid_reg;
    assign features.data  = out_data_reg;

    a_empty_result_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.has_feature |->
            out_data_reg.end_of_sequence && out_data_reg.feature == '0
            && out_data_reg.bad_symbol == 1'b0)
        else $error("result without window not an end-of-sequence marker");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && en2 |=> out_valid_reg)
        else $error("stage one transaction lost on advance");

endmodule

`default_nettype wire

### design/kmer_base16_window_encoder.sv
// ----------------------------------------------------------------------------
// kmer_base16_window_encoder
// Encodes a character stream into scaled base-16 k-mer window features.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                           handshake
//  chars     in    symbol[7:0], final_char                           valid/ready
//  features  out   feature[31:0] s, window_index[15:0], has_feature,  valid/ready
//                  bad_symbol, end_of_sequence
//  cfg_*     in    cfg_index[2:0], cfg_data[52:0]                    cfg_we
//
//  One character per cycle sustained while features is not stalled; a result
//  leaves after its character is taken, via queue write, multiply stage and output register.
//  The multiply is split into a 24x24-bit low product and a 24x29-bit high
//  product, both formed in the multiply stage.
//  Reset clears all sequence state at once; no clearing pass.
//  chars.ready drops only while the queue (two entries by default) is full,
//  which happens only when features is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_base16_window_encoder #(
    parameter int K_MAX         = kbwe_pkg::K_MAX_DEF,
    parameter int POSITION_BITS = kbwe_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = kbwe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    kbwe_stream_if.sink                           chars,
    kbwe_stream_if.source                         features,
    input  wire logic                             cfg_we,
    input  wire logic [kbwe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kbwe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kbwe_pkg::cfg_t   cfg_reg, cfg_next;
    logic             push, pop, q_full, q_valid;
    kbwe_pkg::entry_t push_data, q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                kbwe_pkg::REG_KMER_LEN:
                    cfg_next.kmer_len = cfg_data[kbwe_pkg::KMER_W-1:0];
                kbwe_pkg::REG_WINDOW_STRIDE:
                    cfg_next.window_stride = cfg_data[kbwe_pkg::STRIDE_W-1:0];
                kbwe_pkg::REG_SEGMENT_LEN:
                    cfg_next.segment_len = cfg_data[kbwe_pkg::SEGMENT_W-1:0];
                kbwe_pkg::REG_SKIP_COUNT:
                    cfg_next.skip_count = cfg_data[kbwe_pkg::SKIP_W-1:0];
                kbwe_pkg::REG_SCALE_FACTOR:
                    cfg_next.scale_factor = cfg_data[kbwe_pkg::SCALE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_len      <= kbwe_pkg::KMER_LEN_RST;
            cfg_reg.window_stride <= kbwe_pkg::WINDOW_STRIDE_RST;
            cfg_reg.segment_len   <= kbwe_pkg::SEGMENT_LEN_RST;
            cfg_reg.skip_count    <= kbwe_pkg::SKIP_COUNT_RST;
            cfg_reg.scale_factor  <= kbwe_pkg::SCALE_FACTOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kbwe_front #(
        .K_MAX         (K_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .chars      (chars),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    kbwe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    kbwe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_factor (cfg_reg.scale_factor),
        .entry_valid  (q_valid),
        .entry        (q_head),
        .pop          (pop),
        .features     (features)
    );

endmodule

`default_nettype wire

### tb/tb_kmer_base16_window_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmer_base16_window_encoder
// Self-checking bench for the k-mer window encoder. A short table of
// characters and register settings runs first, then random sequences under
// random register settings, then a closing run of sequences with no idling.
// Every output transaction is compared field by field with an in-bench model
// of the encoder, or with the expected values that the table gives.
// ----------------------------------------------------------------------------

module tb_kmer_base16_window_encoder;

    localparam int          K_LIMIT       = kbwe_pkg::K_MAX_DEF;
    localparam int unsigned RANDOM_CHARS  = 950;
    localparam int unsigned TAIL_SEQ_LEN  = 40;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 200;

    localparam logic [kbwe_pkg::CHARPOS_W-1:0] POS_SAT = {kbwe_pkg::CHARPOS_W{1'b1}};
    localparam logic signed [kbwe_pkg::FEATURE_W-1:0] Q30_NEG = -32'sd1073741824;
    localparam kbwe_pkg::cfg_t RESET_SETTINGS = '{kbwe_pkg::KMER_LEN_RST,
                                                  kbwe_pkg::WINDOW_STRIDE_RST,
                                                  kbwe_pkg::SEGMENT_LEN_RST,
                                                  kbwe_pkg::SKIP_COUNT_RST,
                                                  kbwe_pkg::SCALE_FACTOR_RST};

    typedef enum bit {PROBE_CFG, PROBE_CHAR} probe_kind_t;

    typedef struct {
        probe_kind_t     kind;
        kbwe_pkg::cfg_t  settings;
        kbwe_pkg::in_t   ch;
        bit              typed;
        kbwe_pkg::out_t  want;
    } probe_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [kbwe_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kbwe_pkg::CFG_DATA_W-1:0]  cfg_data;

    kbwe_stream_if #(.T(kbwe_pkg::in_t))  chars_if ();
    kbwe_stream_if #(.T(kbwe_pkg::out_t)) features_if ();

    kmer_base16_window_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .features  (features_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Encoder model: settings and per-sequence state
    kbwe_pkg::cfg_t                  cur_cfg;
    logic [kbwe_pkg::CHARPOS_W-1:0]  seq_pos;
    logic [kbwe_pkg::WIN_W-1:0]      win_acc;
    logic [kbwe_pkg::STRIDE_W-1:0]   stride_ctr;
    logic [kbwe_pkg::INDEX_W-1:0]    win_count;
    logic [2:0]                      clean_run;

    string  iupac = "AMVHCRSNWUYBGKDT";
    kbwe_pkg::out_t pending_features [$];
    probe_t probes [$];
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;
    bit     src_bursts  = 1'b0;
    bit     sink_bursts = 1'b0;
    int unsigned stall_left = 0;
    kbwe_pkg::out_t head_feature;

    function automatic void clear_seq();
        seq_pos    = '0;
        win_acc    = '0;
        stride_ctr = '0;
        win_count  = '0;
        clean_run  = 3'(K_LIMIT);
    endfunction

    function automatic logic [kbwe_pkg::SCALE_W-1:0] nominal_scale(input int unsigned k);
        longint unsigned d;
        d = (64'd1 << (4 * k)) - 64'd1;
        return kbwe_pkg::SCALE_W'((((64'd1 << 56) / d) + 64'd1) >> 1);
    endfunction

    // Advances the model by one character; returns 1 when a transaction is due
    function automatic bit encode_char(input kbwe_pkg::in_t c, output kbwe_pkg::out_t r);
        int unsigned     k;
        int unsigned     stride;
        int unsigned     p;
        logic [3:0]      code;
        bit              found;
        bit              aligned;
        bit              emit;
        bit              dirty;
        longint unsigned x;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned prod;
        logic [kbwe_pkg::FEATURE_W-1:0] feat;
        logic [kbwe_pkg::INDEX_W-1:0]   idx;

        k      = (cur_cfg.kmer_len == 0) ? 1 :
                 (cur_cfg.kmer_len > K_LIMIT) ? K_LIMIT : cur_cfg.kmer_len;
        stride = (cur_cfg.window_stride == 0) ? 1 : cur_cfg.window_stride;
        emit   = 1'b0;
        dirty  = 1'b0;
        found  = 1'b0;
        code   = '0;
        feat   = '0;
        idx    = '0;
        if (seq_pos >= cur_cfg.skip_count)
        begin
            p = seq_pos - cur_cfg.skip_count;
            for (int i = 0; i < 16; i++)
            begin
                if (!found && iupac[i] == c.symbol)
                begin
                    code  = 4'(i);
                    found = 1'b1;
                end
            end
            // unknown characters enter the window as code 0
            win_acc = kbwe_pkg::WIN_W'(((32'(win_acc) << 4) | 32'(code)) &
                                       ((32'd1 << (4 * k)) - 32'd1));
            if (!found)
                clean_run = '0;
            else if (clean_run < K_LIMIT)
                clean_run = clean_run + 3'd1;
            if (p + 1 >= k)
            begin
                aligned = (stride_ctr == 0);
                if (32'(stride_ctr) + 1 >= stride)
                    stride_ctr = '0;
                else
                    stride_ctr = stride_ctr + 8'd1;
                if (aligned && p < cur_cfg.segment_len)
                begin
                    emit  = 1'b1;
                    dirty = (clean_run < k);
                    x     = win_acc;
                    hi    = cur_cfg.scale_factor >> 24;
                    lo    = cur_cfg.scale_factor[23:0];
                    prod  = x * hi + ((x * lo) >> 24);
                    if (prod >= 64'h8000_0000)
                        feat = kbwe_pkg::Q30_ONE;
                    else
                        feat = kbwe_pkg::FEATURE_W'(prod - 64'h4000_0000);
                    idx = win_count;
                    if (win_count != {kbwe_pkg::INDEX_W{1'b1}})
                        win_count = win_count + 16'd1;
                end
            end
        end
        if (seq_pos != POS_SAT)
            seq_pos = seq_pos + 17'd1;

        r = '0;
        if (emit)
        begin
            r.feature      = feat;
            r.window_index = idx;
            r.has_feature  = 1'b1;
            r.bad_symbol   = dirty;
        end
        r.end_of_sequence = c.final_char;
        if (c.final_char)
            clear_seq();
        return emit || c.final_char;
    endfunction

    function automatic kbwe_pkg::symbol_t pick_symbol();
        if ($urandom_range(0, 99) < 85)
            return kbwe_pkg::symbol_t'(iupac[$urandom_range(0, 15)]);
        return kbwe_pkg::symbol_t'($urandom_range(0, 255));
    endfunction

    function automatic void add_cfg(input int unsigned k, input int unsigned stride,
                                    input int unsigned seg, input int unsigned skip,
                                    input logic [kbwe_pkg::SCALE_W-1:0] scale);
        probe_t pr;
        pr          = '{kind: PROBE_CFG, default: '0};
        pr.settings = '{kbwe_pkg::KMER_W'(k), kbwe_pkg::STRIDE_W'(stride),
                        kbwe_pkg::SEGMENT_W'(seg), kbwe_pkg::SKIP_W'(skip), scale};
        probes.push_back(pr);
    endfunction

    function automatic void add_char(input kbwe_pkg::symbol_t sym, input bit fin);
        probe_t pr;
        pr      = '{kind: PROBE_CHAR, default: '0};
        pr.ch   = '{sym, fin};
        probes.push_back(pr);
    endfunction

    function automatic void add_typed(input kbwe_pkg::symbol_t sym, input bit fin,
                                      input logic signed [kbwe_pkg::FEATURE_W-1:0] feat,
                                      input int unsigned idx, input bit has,
                                      input bit bad, input bit eos);
        probe_t pr;
        pr       = '{kind: PROBE_CHAR, default: '0};
        pr.ch    = '{sym, fin};
        pr.typed = 1'b1;
        pr.want  = '{feat, kbwe_pkg::INDEX_W'(idx), has, bad, eos};
        probes.push_back(pr);
    endfunction

    // Lets the pipeline empty before registers change
    task automatic wait_quiet();
        chars_if.valid <= 1'b0;
        while (pending_features.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input kbwe_pkg::cfg_t s);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= kbwe_pkg::REG_KMER_LEN;
        cfg_data  <= kbwe_pkg::CFG_DATA_W'(s.kmer_len);
        @(posedge clk);
        cfg_index <= kbwe_pkg::REG_WINDOW_STRIDE;
        cfg_data  <= kbwe_pkg::CFG_DATA_W'(s.window_stride);
        @(posedge clk);
        cfg_index <= kbwe_pkg::REG_SEGMENT_LEN;
        cfg_data  <= kbwe_pkg::CFG_DATA_W'(s.segment_len);
        @(posedge clk);
        cfg_index <= kbwe_pkg::REG_SKIP_COUNT;
        cfg_data  <= kbwe_pkg::CFG_DATA_W'(s.skip_count);
        @(posedge clk);
        cfg_index <= kbwe_pkg::REG_SCALE_FACTOR;
        cfg_data  <= kbwe_pkg::CFG_DATA_W'(s.scale_factor);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = s;
    endtask

    task automatic push_char(input kbwe_pkg::in_t c, input bit typed,
                             input kbwe_pkg::out_t want);
        kbwe_pkg::out_t got;
        if (src_bursts && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.data  <= c;
        do
            @(posedge clk);
        while (chars_if.ready !== 1'b1);
        if (encode_char(c, got))
            pending_features.push_back(typed ? want : got);
    endtask

    task automatic send_sequence(input int unsigned len);
        kbwe_pkg::in_t  c;
        kbwe_pkg::out_t none;
        none = '0;
        for (int unsigned n = 1; n <= len; n++)
        begin
            c.symbol     = pick_symbol();
            c.final_char = (n == len);
            push_char(c, 1'b0, none);
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Output side: random back-pressure bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left        <= stall_left - 1;
            features_if.ready <= (stall_left == 1);
        end
        else if (sink_bursts && $urandom_range(0, 7) == 0)
        begin
            stall_left        <= $urandom_range(1, 19);
            features_if.ready <= 1'b0;
        end
        else
        begin
            features_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && features_if.valid && features_if.ready)
        begin
            if (pending_features.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("features: transaction with nothing expected");
            end
            else
            begin
                head_feature = pending_features.pop_front();
                compare_field("feature", longint'(head_feature.feature),
                              longint'(features_if.data.feature));
                compare_field("window_index", head_feature.window_index,
                              features_if.data.window_index);
                compare_field("has_feature", head_feature.has_feature,
                              features_if.data.has_feature);
                compare_field("bad_symbol", head_feature.bad_symbol,
                              features_if.data.bad_symbol);
                compare_field("end_of_sequence", head_feature.end_of_sequence,
                              features_if.data.end_of_sequence);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready) ||
            (features_if.valid && features_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("kmer_base16_window_encoder: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        kbwe_pkg::cfg_t s;
        int unsigned    keff;
        int unsigned    len;
        int unsigned    rand_chars;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        chars_if.valid    = 1'b0;
        chars_if.data     = '0;
        features_if.ready = 1'b0;
        cur_cfg           = RESET_SETTINGS;
        clear_seq();
        rand_chars        = 0;

        // Defaults after reset: skip of 200 leaves a lone final character bare
        add_typed("A", 1'b1, '0, 0, 1'b0, 1'b0, 1'b1);
        // One-character windows, every character emits
        add_cfg(1, 1, 65535, 0, nominal_scale(1));
        add_typed("A", 1'b0, Q30_NEG, 0, 1'b1, 1'b0, 1'b0);
        add_typed("T", 1'b0, kbwe_pkg::Q30_ONE, 1, 1'b1, 1'b0, 1'b0);
        add_typed(8'h00, 1'b0, Q30_NEG, 2, 1'b1, 1'b1, 1'b0);
        add_typed(8'hFF, 1'b0, Q30_NEG, 3, 1'b1, 1'b1, 1'b0);
        add_char("G", 1'b1);
        // Widest window, stride 2, bad characters inside the skipped prefix
        add_cfg(6, 2, 65535, 2, nominal_scale(6));
        add_char("n", 1'b0);
        add_char("n", 1'b0);
        add_char("A", 1'b0);
        add_char("C", 1'b0);
        add_char("G", 1'b0);
        add_char("T", 1'b0);
        add_char("K", 1'b0);
        add_char("D", 1'b0);
        add_char("T", 1'b1);
        // kmer 7 acts as 6, stride 0 acts as 1, oversized scale saturates
        add_cfg(7, 0, 65535, 0, kbwe_pkg::SCALE_W'(64'd1 << 52));
        repeat (5) add_char("T", 1'b0);
        add_typed("T", 1'b0, kbwe_pkg::Q30_ONE, 0, 1'b1, 1'b0, 1'b0);
        add_typed("A", 1'b1, kbwe_pkg::Q30_ONE, 1, 1'b1, 1'b0, 1'b1);
        // kmer 0 acts as 1, segment of one, minimum scale
        add_cfg(0, 255, 1, 0, 53'd1);
        add_typed("C", 1'b0, Q30_NEG, 0, 1'b1, 1'b0, 1'b0);
        add_typed("G", 1'b1, '0, 0, 1'b0, 1'b0, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        src_bursts  = 1'b1;
        sink_bursts = 1'b1;
        foreach (probes[i])
        begin
            if (probes[i].kind == PROBE_CFG)
                load_settings(probes[i].settings);
            else
                push_char(probes[i].ch, probes[i].typed, probes[i].want);
        end

        while (rand_chars < RANDOM_CHARS)
        begin
            s.kmer_len = kbwe_pkg::KMER_W'($urandom_range(0, 7));
            keff = (s.kmer_len == 0) ? 1 : (s.kmer_len > K_LIMIT) ? K_LIMIT : s.kmer_len;
            case ($urandom_range(0, 5))
                0:       s.window_stride = 8'd1;
                1:       s.window_stride = 8'd255;
                2:       s.window_stride = 8'd0;
                default: s.window_stride = kbwe_pkg::STRIDE_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 6))
                0:       s.segment_len = 16'd1;
                1:       s.segment_len = 16'hFFFF;
                2:       s.segment_len = 16'd0;
                3:       s.segment_len = kbwe_pkg::SEGMENT_W'($urandom);
                default: s.segment_len = kbwe_pkg::SEGMENT_W'($urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 9))
                0:       s.skip_count = 16'hFFFF;
                1:       s.skip_count = kbwe_pkg::SKIP_W'($urandom_range(300, 65535));
                2:       s.skip_count = 16'd0;
                default: s.skip_count = kbwe_pkg::SKIP_W'($urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       s.scale_factor = 53'd1;
                1:       s.scale_factor = 53'd0;
                2:       s.scale_factor = kbwe_pkg::SCALE_W'(64'd1 << 52);
                3:       s.scale_factor = kbwe_pkg::SCALE_W'({$urandom, $urandom});
                default: s.scale_factor = nominal_scale(keff);
            endcase
            src_bursts  = ($urandom_range(0, 3) != 0);
            sink_bursts = ($urandom_range(0, 3) != 0);
            load_settings(s);

            repeat ($urandom_range(1, 5))
            begin
                // a huge skip only ever gives bare end-of-sequence transactions
                if (s.skip_count > 300)
                    len = $urandom_range(1, 30);
                else if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, s.skip_count + keff);
                else
                    len = s.skip_count + $urandom_range(0, 4 * keff + 40);
                send_sequence(len);
                rand_chars += len;
            end
        end

        // Closing run, no idling on either side
        src_bursts  = 1'b0;
        sink_bursts = 1'b0;
        load_settings('{kbwe_pkg::KMER_W'(1), kbwe_pkg::STRIDE_W'(1),
                        kbwe_pkg::SEGMENT_W'(16'hFFFF), kbwe_pkg::SKIP_W'(0),
                        nominal_scale(1)});
        send_sequence(TAIL_SEQ_LEN);
        send_sequence(TAIL_SEQ_LEN);
        wait_quiet();

        if (mismatches == 0)
            $display("kmer_base16_window_encoder: match");
        else
            $display("kmer_base16_window_encoder: mismatch");
        $finish;
    end

endmodule

### sim.f
design/kbwe_pkg.sv
design/kbwe_stream_if.sv
design/kbwe_front.sv
design/kbwe_fifo.sv
design/kbwe_back.sv
design/kmer_base16_window_encoder.sv
tb/tb_kmer_base16_window_encoder.sv
